### hw/rtl/nnt_pkg.sv
// Shared types for the nearest-neighbor tour builder.
// Used by nnt_dist and nearest_neighbor_tour; depends on nothing.

package nnt_pkg;

	localparam int unsigned NodeIdxBits   = 6;
	localparam int unsigned NodeCountBits = 7;
	localparam int unsigned RegDataBits   = 32;

	// register index of node_count
	localparam logic RegNodeCount = 1'b0;

	// tuser code on the input side
	localparam logic CmdLoad  = 1'b0;
	localparam logic CmdBuild = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_CUR,
		ST_EMIT,
		ST_RD,
		ST_DIFF,
		ST_MULX,
		ST_MULY,
		ST_CMP
	} nnt_state_t;

	// sequencer strobes into the distance unit
	typedef struct packed {
		logic cur_from_ram;
		logic cur_from_best;
		logic scan_clr;
		logic diff_en;
		logic mulx_en;
		logic muly_en;
		logic cmp_en;
	} nnt_ctrl_t;

endpackage

### hw/rtl/nnt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module nnt_ram #(
	parameter int unsigned WIDTH = 42,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/nnt_dist.sv
// Distance unit: current point, candidate differences, one shared squaring
// multiplier, and the running minimum. Depends on nnt_pkg.

module nnt_dist #(
	parameter int unsigned COORD_BITS = 21,
	parameter int unsigned IDX_BITS   = 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  nnt_pkg::nnt_ctrl_t      ctrl,
	input  logic [2*COORD_BITS-1:0] rdata,
	input  logic [IDX_BITS-1:0]     cand_idx,
	output logic [IDX_BITS-1:0]     best_idx
);

	import nnt_pkg::*;

	localparam int unsigned SqBits = 2 * COORD_BITS;

	logic signed [COORD_BITS-1:0] rd_x, rd_y;
	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q;
	logic signed [COORD_BITS-1:0] cand_x_q, cand_y_q;
	logic signed [COORD_BITS-1:0] best_x_q, best_y_q;
	logic signed [COORD_BITS:0]   diff_x, diff_y;
	logic [COORD_BITS-1:0]        abs_x, abs_y;
	logic [COORD_BITS-1:0]        dx_q, dy_q;
	logic [COORD_BITS-1:0]        mul_in;
	logic [SqBits-1:0]            prod;
	logic [SqBits-1:0]            sq_x_q, sq_y_q;
	logic [SqBits:0]              sum;
	logic [SqBits:0]              best_sum_q;
	logic [IDX_BITS-1:0]          best_idx_q;
	logic                         found_q;
	logic                         take;

	assign rd_x = rdata[COORD_BITS-1:0];
	assign rd_y = rdata[2*COORD_BITS-1:COORD_BITS];

	assign diff_x = {rd_x[COORD_BITS-1], rd_x} - {cur_x_q[COORD_BITS-1], cur_x_q};
	assign diff_y = {rd_y[COORD_BITS-1], rd_y} - {cur_y_q[COORD_BITS-1], cur_y_q};
	assign abs_x  = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
	assign abs_y  = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];

	// the one multiplier, squaring dx then dy on consecutive cycles
	assign mul_in = ctrl.muly_en ? dy_q : dx_q;
	assign prod   = SqBits'(mul_in) * SqBits'(mul_in);

	assign sum  = {1'b0, sq_x_q} + {1'b0, sq_y_q};
	// strict compare: ties keep the lower index
	assign take = !found_q || (sum < best_sum_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctrl.scan_clr) begin
			found_q <= 1'b0;
		end else if (ctrl.cmp_en) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.cur_from_ram) begin
			cur_x_q <= rd_x;
			cur_y_q <= rd_y;
		end else if (ctrl.cur_from_best) begin
			cur_x_q <= best_x_q;
			cur_y_q <= best_y_q;
		end
		if (ctrl.diff_en) begin
			dx_q     <= abs_x;
			dy_q     <= abs_y;
			cand_x_q <= rd_x;
			cand_y_q <= rd_y;
		end
		if (ctrl.mulx_en) begin
			sq_x_q <= prod;
		end
		if (ctrl.muly_en) begin
			sq_y_q <= prod;
		end
		if (ctrl.cmp_en && take) begin
			best_sum_q <= sum;
			best_idx_q <= cand_idx;
			best_x_q   <= cand_x_q;
			best_y_q   <= cand_y_q;
		end
	end

	assign best_idx = best_idx_q;

endmodule

### hw/rtl/nearest_neighbor_tour.sv
// Greedy nearest-neighbor tour builder: sequencer, visited marks, point RAM.
// Depends on nnt_pkg, nnt_ram and nnt_dist.
//
// Usage:
//   Input stream (s_*): s_tuser selects the command. A load word stores
//   (x, y) at the next load position; loads beyond node_count are dropped.
//   A build word starts a tour at start_node.
//   Output stream (m_*): one word per tour point, tour_node in m_tdata,
//   m_tlast on the final point. A start node not below node_count gives a
//   single word with m_tuser (error) and m_tlast set.
//   APB register 0 (byte address 0) is node_count; writing it also rewinds
//   the load position. Write it only while the block is idle.
// Timing: loads may follow back to back. The build time is set by the
//   five-step candidate pass (RAM read, difference, square x, square y, add
//   and compare) through the single squaring multiplier, run for each
//   unvisited point at each tour position. s_tready stays low for the
//   whole build.
// Stall: the result word sits in an output register; the sequencer waits
//   while that register is still full and not taken.
// Reset: node_count returns to 64, load position and visited marks clear,
//   the point RAM holds no defined contents until loaded.

module nearest_neighbor_tour #(
	parameter int unsigned MAX_NODES  = 64,
	parameter int unsigned COORD_BITS = 21
) (
	input  logic clk,
	input  logic arst_n,

	// s_tdata: point_x, point_y, start_node (lowest bit first), zero padded
	input  logic [((2*COORD_BITS+6+7)/8)*8-1:0] s_tdata,
	// s_tuser: command
	input  logic [0:0]                          s_tuser,
	input  logic                                s_tvalid,
	output logic                                s_tready,

	// m_tdata: tour_node, zero padded
	output logic [7:0]                          m_tdata,
	// m_tuser: start_error
	output logic [0:0]                          m_tuser,
	output logic                                m_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,

	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [2:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	import nnt_pkg::*;

	localparam int unsigned IdxBits = $clog2(MAX_NODES);
	localparam int unsigned CntBits = $clog2(MAX_NODES + 1);
	localparam int unsigned PtBits  = 2 * COORD_BITS;

	nnt_state_t state_q, state_d;
	nnt_ctrl_t  ctrl;

	logic [NodeCountBits-1:0] node_count_q;
	logic [CntBits-1:0]       eff_cnt;
	logic [CntBits-1:0]       load_pos_q;
	logic [CntBits-1:0]       pos_q;
	logic [CntBits-1:0]       j_q;
	logic [MAX_NODES-1:0]     visited_q;
	logic [NodeIdxBits-1:0]   start_q;
	logic [IdxBits-1:0]       res_node_q;
	logic                     res_last_q;
	logic                     res_err_q;
	logic [NodeIdxBits-1:0]   out_node_q;
	logic                     out_last_q;
	logic                     out_err_q;
	logic                     m_tvalid_q;

	logic                     cfg_wr;
	logic                     in_acc;
	logic                     is_build;
	logic                     ram_we;
	logic [IdxBits-1:0]       ram_raddr;
	logic [PtBits-1:0]        ram_wdata;
	logic [PtBits-1:0]        ram_rdata;
	logic [IdxBits-1:0]       best_idx;
	logic [IdxBits-1:0]       j_idx;
	logic                     start_bad;
	logic                     scan_done;
	logic                     out_free;
	logic                     load_out;

	assign eff_cnt = (node_count_q > NodeCountBits'(MAX_NODES)) ?
		CntBits'(MAX_NODES) : node_count_q[CntBits-1:0];

	assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == RegNodeCount);
	assign in_acc   = s_tvalid && s_tready;
	assign is_build = (s_tuser[0] == CmdBuild);

	assign j_idx     = j_q[IdxBits-1:0];
	assign start_bad = {1'b0, start_q} >= NodeCountBits'(eff_cnt);
	assign scan_done = (j_q == eff_cnt);
	assign out_free  = !m_tvalid_q || m_tready;

	assign ram_wdata = s_tdata[PtBits-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && is_build) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				state_d = start_bad ? ST_EMIT : ST_CUR;
			end
			ST_CUR: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = res_last_q ? ST_IDLE : ST_RD;
				end
			end
			ST_RD: begin
				if (scan_done) begin
					state_d = ST_EMIT;
				end else if (!visited_q[j_idx]) begin
					state_d = ST_DIFF;
				end
			end
			ST_DIFF: state_d = ST_MULX;
			ST_MULX: state_d = ST_MULY;
			ST_MULY: state_d = ST_CMP;
			ST_CMP:  state_d = ST_RD;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_raddr = j_idx;
		load_out  = 1'b0;
		ctrl      = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				ram_we   = in_acc && !is_build && (load_pos_q < eff_cnt);
			end
			ST_START: begin
				ram_raddr = start_q[IdxBits-1:0];
			end
			ST_CUR: begin
				ctrl.cur_from_ram = 1'b1;
			end
			ST_EMIT: begin
				load_out      = out_free;
				ctrl.scan_clr = 1'b1;
			end
			ST_RD: begin
				ctrl.cur_from_best = scan_done;
			end
			ST_DIFF: ctrl.diff_en = 1'b1;
			ST_MULX: ctrl.mulx_en = 1'b1;
			ST_MULY: ctrl.muly_en = 1'b1;
			ST_CMP:  ctrl.cmp_en  = 1'b1;
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			node_count_q <= NodeCountBits'(64);
			load_pos_q   <= '0;
			pos_q        <= '0;
			j_q          <= '0;
			visited_q    <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				node_count_q <= pwdata[NodeCountBits-1:0];
				load_pos_q   <= '0;
			end else if (ram_we) begin
				load_pos_q <= load_pos_q + 1'b1;
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_START: begin
					pos_q <= '0;
					if (!start_bad) begin
						visited_q <= MAX_NODES'(1) << start_q[IdxBits-1:0];
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						pos_q <= pos_q + 1'b1;
						j_q   <= '0;
					end
				end
				ST_RD: begin
					if (scan_done) begin
						visited_q[best_idx] <= 1'b1;
					end else if (visited_q[j_idx]) begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_CMP: begin
					j_q <= j_q + 1'b1;
				end
				default: begin
					j_q <= j_q;
				end
			endcase
		end
	end

	// result and output word registers
	always_ff @(posedge clk) begin
		if (in_acc && is_build) begin
			start_q <= s_tdata[PtBits +: NodeIdxBits];
		end
		if (state_q == ST_START) begin
			res_node_q <= '0;
			res_last_q <= 1'b1;
			res_err_q  <= 1'b1;
		end else if (state_q == ST_CUR) begin
			res_node_q <= start_q[IdxBits-1:0];
			res_last_q <= (eff_cnt == CntBits'(1));
			res_err_q  <= 1'b0;
		end else if ((state_q == ST_RD) && scan_done) begin
			res_node_q <= best_idx;
			res_last_q <= ((pos_q + 1'b1) == eff_cnt);
			res_err_q  <= 1'b0;
		end
		if (load_out) begin
			out_node_q <= NodeIdxBits'(res_node_q);
			out_last_q <= res_last_q;
			out_err_q  <= res_err_q;
		end
	end

	nnt_ram #(
		.WIDTH (PtBits),
		.DEPTH (MAX_NODES)
	) u_pts (
		.clk   (clk),
		.we    (ram_we),
		.waddr (load_pos_q[IdxBits-1:0]),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	nnt_dist #(
		.COORD_BITS (COORD_BITS),
		.IDX_BITS   (IdxBits)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.rdata    (ram_rdata),
		.cand_idx (j_idx),
		.best_idx (best_idx)
	);

	assign m_tdata  = {2'b00, out_node_q};
	assign m_tuser  = out_err_q;
	assign m_tlast  = out_last_q;
	assign m_tvalid = m_tvalid_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == RegNodeCount) ?
		{{(RegDataBits - NodeCountBits){1'b0}}, node_count_q} : '0;

	// load position never runs past the active point count
	a_load_pos: assert property (@(posedge clk) disable iff (!arst_n)
		load_pos_q <= eff_cnt)
		else $error("load position beyond node count");

	// a new result word never overwrites one still waiting
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!m_tvalid_q || m_tready))
		else $error("output word overwritten");

	// a candidate under evaluation was not already in the tour
	a_cand_unvisited: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIFF) |-> !visited_q[j_idx])
		else $error("visited point evaluated");

	// an error word always closes the tour
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> m_tlast)
		else $error("error word without tlast");

	// a scan ends with exactly pos+1 points marked
	a_scan_marks: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_RD) && scan_done) |=>
			($countones(visited_q) == int'(pos_q) + 1))
		else $error("visited mark count off");

endmodule

### bench/nnt_tour_checker.sv
`timescale 1ns / 1ps
// Checker for nearest_neighbor_tour: watches the APB, input and output streams,
// predicts every tour word from its own copy of the points and compares in order.
// Depends on nnt_pkg only.

module nnt_tour_checker
	import nnt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic [47:0] s_tdata,
	input  logic [0:0]  s_tuser,
	input  logic        s_tvalid,
	input  logic        s_tready,

	input  logic [7:0]  m_tdata,
	input  logic [0:0]  m_tuser,
	input  logic        m_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,

	output int          fail_count,
	output int          pending,
	output int          words_checked,
	output int          points_stored,
	output int          tours_started,
	output int          start_errors
);

	localparam int MaxNodes  = 64;
	localparam int CoordBits = 21;
	localparam logic [2:0] NodeCountAddr = 3'(4 * RegNodeCount);

	typedef struct packed {
		logic [5:0] node;
		logic       last;
		logic       err;
	} tour_word_t;

	tour_word_t tour_q[$];

	logic [6:0] node_cnt;
	logic [6:0] load_pos;
	logic signed [CoordBits-1:0] px [MaxNodes];
	logic signed [CoordBits-1:0] py [MaxNodes];

	function automatic int eff_count();
		return (node_cnt > MaxNodes) ? MaxNodes : int'(node_cnt);
	endfunction

	// exact squared distance; 21-bit coordinates fit easily in 64 bits
	function automatic longint unsigned sq_dist(int a, int b);
		longint dx;
		longint dy;
		dx = longint'(px[a]) - longint'(px[b]);
		dy = longint'(py[a]) - longint'(py[b]);
		return longint'(dx * dx + dy * dy);
	endfunction

	// append one expected word at the tail of the queue
	function automatic void queue_word(input tour_word_t w);
		tour_q.insert(tour_q.size(), w);
	endfunction

	task automatic predict_tour(input logic [5:0] start);
		int cnt;
		int cur;
		int best;
		bit seen [MaxNodes];
		bit found;
		longint unsigned d;
		longint unsigned best_d;
		tour_word_t w;
		cnt = eff_count();
		if (int'(start) >= cnt) begin
			w.node = '0;
			w.last = 1'b1;
			w.err  = 1'b1;
			queue_word(w);
			start_errors++;
			return;
		end
		tours_started++;
		foreach (seen[j])
			seen[j] = 1'b0;
		cur = start;
		seen[cur] = 1'b1;
		w.node = start;
		w.last = (cnt == 1);
		w.err  = 1'b0;
		queue_word(w);
		for (int pos = 1; pos < cnt; pos++) begin
			found  = 1'b0;
			best   = 0;
			best_d = 0;
			// strict compare keeps the lowest index on ties
			for (int j = 0; j < cnt; j++) begin
				if (!seen[j]) begin
					d = sq_dist(cur, j);
					if (!found || d < best_d) begin
						found  = 1'b1;
						best   = j;
						best_d = d;
					end
				end
			end
			seen[best] = 1'b1;
			cur = best;
			w.node = 6'(best);
			w.last = (pos == cnt - 1);
			queue_word(w);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		tour_word_t want;
		if (!arst_n) begin
			node_cnt = 7'd64;
			load_pos = '0;
			tour_q.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == NodeCountAddr) begin
				node_cnt = pwdata[6:0];
				load_pos = '0;
			end
			// results before new work: a word taken now never belongs to this edge's input
			if (m_tvalid && m_tready) begin
				if (tour_q.size() == 0) begin
					$error("tour word with nothing pending: tour_node %0d", m_tdata[5:0]);
					fail_count++;
				end else begin
					want = tour_q.pop_front();
					words_checked++;
					if (m_tdata[5:0] !== want.node) begin
						$error("tour_node: expected %0d, got %0d", want.node, m_tdata[5:0]);
						fail_count++;
					end
					if (m_tlast !== want.last) begin
						$error("last_in_tour: expected %0d, got %0d", want.last, m_tlast);
						fail_count++;
					end
					if (m_tuser[0] !== want.err) begin
						$error("start_error: expected %0d, got %0d", want.err, m_tuser[0]);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == CmdLoad) begin
					if (int'(load_pos) < eff_count()) begin
						px[load_pos[5:0]] = s_tdata[20:0];
						py[load_pos[5:0]] = s_tdata[41:21];
						load_pos = load_pos + 7'd1;
						points_stored++;
					end
				end else begin
					predict_tour(s_tdata[47:42]);
				end
			end
			pending <= tour_q.size();
		end
	end

endmodule

### bench/nearest_neighbor_tour_test.sv
`timescale 1ns / 1ps
// Top of the nearest_neighbor_tour bench: clock, reset, point and build stimulus,
// APB count writes and random stalls. Depends on nnt_pkg, the block and nnt_tour_checker.

module nearest_neighbor_tour_test;

	import nnt_pkg::*;

	localparam logic [2:0] NodeCountAddr = 3'(4 * RegNodeCount);
	localparam int CycleLimit = 500000;
	localparam int DrainCycles = 16;
	localparam int TargetItems = 140;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic [47:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;

	logic [7:0]  m_tdata;
	logic [0:0]  m_tuser;
	logic        m_tlast;
	logic        m_tvalid;
	logic        m_tready = 1'b0;

	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int fail_count;
	int pending;
	int words_checked;
	int points_stored;
	int tours_started;
	int start_errors;

	bit  quiet = 1'b0;
	int  stall_left = 0;

	// stimulus-side bookkeeping so a build never touches an unwritten point
	bit [63:0] loaded_mask = '0;
	int        load_ptr = 0;
	int        eff = 64;
	int        items = 0;

	nearest_neighbor_tour dut (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	nnt_tour_checker tour_check (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.fail_count(fail_count), .pending(pending), .words_checked(words_checked),
		.points_stored(points_stored), .tours_started(tours_started),
		.start_errors(start_errors)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver stalls in random bursts
	always @(posedge clk) begin
		if (quiet) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			stall_left <= $urandom_range(0, 4);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		repeat (CycleLimit) @(posedge clk);
		$display("timed out after %0d cycles, %0d words still pending", CycleLimit, pending);
		$display("FAIL");
		$finish;
	end

	// valid stays high after a handshake; the next call or wait_idle moves it
	task automatic send_word(input logic cmd, input logic [20:0] x, input logic [20:0] y,
			input logic [5:0] start);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {start, y, x};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic set_count(input int value);
		wait_idle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= NodeCountAddr;
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		load_ptr = 0;
		eff = (value > 64) ? 64 : value;
	endtask

	task automatic load_point(input int x, input int y);
		bit taken;
		taken = load_ptr < eff;
		send_word(CmdLoad, 21'(x), 21'(y), 6'($urandom_range(0, 63)));
		if (taken) begin
			loaded_mask[load_ptr] = 1'b1;
			load_ptr++;
			items++;
		end
	endtask

	task automatic build_from(input int start);
		send_word(CmdBuild, 21'($urandom), 21'($urandom), 6'(start));
		items++;
	endtask

	function automatic bit tour_ready();
		for (int i = 0; i < eff; i++)
			if (!loaded_mask[i])
				return 1'b0;
		return eff > 0;
	endfunction

	// mostly good starts; bad ones where the count leaves room for them
	task automatic random_build();
		if (eff < 64 && ($urandom_range(0, 4) == 0 || !tour_ready()))
			build_from($urandom_range(eff, 63));
		else if (tour_ready())
			build_from($urandom_range(0, eff - 1));
	endtask

	function automatic int rand_coord(input int style);
		case (style)
			0: rand_coord = int'($urandom_range(0, 6)) - 3;   // dense cluster, many ties
			1: rand_coord = int'($urandom_range(0, 4000)) - 2000;
			default: rand_coord = int'($signed(21'($urandom)));
		endcase
	endfunction

	initial begin
		int n;
		int k;
		int style;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// four points, two of them at the coordinate extremes
		set_count(4);
		load_point(-1048576, -1048576);
		load_point(1048575, 1048575);
		load_point(0, 0);
		load_point(-1, 1);
		load_point(12345, -6789);   // past the count, dropped
		build_from(0);
		wait_idle();
		build_from(3);
		build_from(2);
		build_from(4);
		build_from(63);

		// equal distances from the start: lower index wins
		set_count(3);
		load_point(0, 0);
		load_point(5, 0);
		load_point(-5, 0);
		build_from(0);
		build_from(1);

		// single point tour
		set_count(1);
		load_point(7, 7);
		build_from(0);
		build_from(1);

		// zero count: loads dropped, every build is a bad start
		set_count(0);
		load_point(100, -100);
		build_from(0);

		// full size once, then an oversized count that acts as the maximum
		set_count(64);
		for (int i = 0; i < 64; i++)
			load_point(rand_coord(2), rand_coord(2));
		build_from($urandom_range(0, 63));
		build_from($urandom_range(0, 63));
		set_count(127);
		build_from(63);
		build_from($urandom_range(0, 63));

		while (items < TargetItems) begin
			if (items >= TargetItems - 30)
				quiet <= 1'b1;
			n = $urandom_range(2, 10);
			set_count(n);
			style = $urandom_range(0, 2);
			k = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n) : n;
			repeat (k) load_point(rand_coord(style), rand_coord(style));
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 2)) load_point(rand_coord(2), rand_coord(2));
			repeat ($urandom_range(1, 3)) random_build();
		end

		wait_idle();
		$display("Stored %0d points, built %0d tours and %0d bad-start builds,",
			points_stored, tours_started, start_errors);
		$display("checked %0d tour words over counts from 0 to 127.", words_checked);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
